/* src/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, codes and helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jse_pkg;

  localparam int OP_W     = 2;
  localparam int CP_W     = 21;
  localparam int BYTE_W   = 8;
  localparam int SEQ_MAX  = 6;
  localparam int LEN_W    = 3;
  localparam int IDX_W    = 3;
  localparam int IN_W     = 24;   // op + code point padded to whole bytes

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
  localparam logic [OP_W-1:0] OP_CHAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd2;

  localparam logic [CP_W-1:0] CTRL_LIMIT = 21'd32;

  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U     = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

  // One item's worth of output bytes, emitted from seq[0] upward
  typedef struct packed {
    logic [SEQ_MAX-1:0][BYTE_W-1:0] seq;
    logic [LEN_W-1:0]               len;
  } esc_seq_t;

  function automatic logic [BYTE_W-1:0] hex_upper(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/jse_front.sv */
// ----------------------------------------------------------------------------
// jse_front
// Decodes one command into its escaped byte sequence and length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_front (
  input  wire logic [jse_pkg::OP_W-1:0] op,
  input  wire logic [jse_pkg::CP_W-1:0] code_point,
  output jse_pkg::esc_seq_t             desc
);

  always_comb begin
    desc.seq = '0;
    desc.len = '0;
    case (op)
      jse_pkg::OP_OPEN, jse_pkg::OP_CLOSE: begin
        desc.seq[0] = jse_pkg::CH_QUOTE;
        desc.len    = 3'd1;
      end
      jse_pkg::OP_CHAR: begin
        if (code_point == {13'd0, jse_pkg::CH_QUOTE} ||
            code_point == {13'd0, jse_pkg::CH_BSL}) begin
          desc.seq[0] = jse_pkg::CH_BSL;
          desc.seq[1] = code_point[7:0];
          desc.len    = 3'd2;
        end else if (code_point == {13'd0, jse_pkg::CH_LF}) begin
          desc.seq[0] = jse_pkg::CH_BSL;
          desc.seq[1] = jse_pkg::CH_N;
          desc.len    = 3'd2;
        end else if (code_point == {13'd0, jse_pkg::CH_TAB}) begin
          desc.seq[0] = jse_pkg::CH_BSL;
          desc.seq[1] = jse_pkg::CH_T;
          desc.len    = 3'd2;
        end else if (code_point < jse_pkg::CTRL_LIMIT) begin
          // \u00XX
          desc.seq[0] = jse_pkg::CH_BSL;
          desc.seq[1] = jse_pkg::CH_U;
          desc.seq[2] = jse_pkg::CH_ZERO;
          desc.seq[3] = jse_pkg::CH_ZERO;
          desc.seq[4] = jse_pkg::hex_upper({3'd0, code_point[4]});
          desc.seq[5] = jse_pkg::hex_upper(code_point[3:0]);
          desc.len    = 3'd6;
        end else if (code_point < 21'h80) begin
          desc.seq[0] = code_point[7:0];
          desc.len    = 3'd1;
        end else if (code_point < 21'h800) begin
          desc.seq[0] = {3'b110, code_point[10:6]};
          desc.seq[1] = {2'b10, code_point[5:0]};
          desc.len    = 3'd2;
        end else if (code_point < 21'h10000) begin
          desc.seq[0] = {4'b1110, code_point[15:12]};
          desc.seq[1] = {2'b10, code_point[11:6]};
          desc.seq[2] = {2'b10, code_point[5:0]};
          desc.len    = 3'd3;
        end else begin
          desc.seq[0] = {5'b11110, code_point[20:18]};
          desc.seq[1] = {2'b10, code_point[17:12]};
          desc.seq[2] = {2'b10, code_point[11:6]};
          desc.seq[3] = {2'b10, code_point[5:0]};
          desc.len    = 3'd4;
        end
      end
      default: begin
        desc.len = '0;  // unused op: nothing emitted
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/jse_fifo.sv */
// ----------------------------------------------------------------------------
// jse_fifo
// Short queue of decoded sequences between the decoder and the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_fifo #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire jse_pkg::esc_seq_t wr_data,
  output logic                   full,
  input  wire logic              pop,
  output jse_pkg::esc_seq_t      rd_data,
  output logic                   not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jse_pkg::esc_seq_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/jse_back.sv */
// ----------------------------------------------------------------------------
// jse_back
// Walks the head sequence one byte per beat into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jse_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire jse_pkg::esc_seq_t            head,
  input  wire logic                         head_valid,
  output logic                              pop,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [jse_pkg::BYTE_W-1:0]        m_tdata,
  output logic                              m_tlast
);

  logic [jse_pkg::IDX_W-1:0] idx;
  logic                      load;
  logic                      take;
  logic                      at_end;

  assign load   = !m_tvalid || m_tready;
  assign take   = load && head_valid;
  assign at_end = (idx == head.len - 3'd1);
  assign pop    = take && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= head_valid;
      end
      if (take) begin
        idx <= at_end ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= head.seq[idx];
      m_tlast <= at_end;
    end
  end

endmodule

`default_nettype wire

/* src/json_string_escape_utf8.sv */
// ----------------------------------------------------------------------------
// json_string_escape_utf8
// Streams commands in and the bytes of a quoted JSON string literal out.
// ----------------------------------------------------------------------------
// Each input beat is a command: open quote, one character, or close quote.
// It produces 0 to 6 output bytes, with tlast on the final byte of each
// command; op value 3 produces nothing. Commands are decoded on entry and
// queued, so a new command is taken every cycle while the queue has room.
// The output side emits one byte per cycle while the sink is ready, and the
// serialiser walking the queued byte sequence sets the sustained rate: a
// command of several bytes holds the queue head until its last byte is taken.
// A command passes through the queue and the registered output stage first.
`timescale 1ns / 1ps
`default_nettype none

module json_string_escape_utf8 #(
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [jse_pkg::IN_W-1:0]     s_tdata,   // [1:0] op, [22:2] code_point
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [jse_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] out_byte
  output logic                              m_tlast    // last
);

  jse_pkg::esc_seq_t desc;
  jse_pkg::esc_seq_t head;
  logic              full;
  logic              head_valid;
  logic              push;
  logic              pop;

  jse_front u_front (
    .op         (s_tdata[1:0]),
    .code_point (s_tdata[22:2]),
    .desc       (desc)
  );

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready && (desc.len != '0);

  jse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (desc),
    .full      (full),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (head_valid)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_string_escape_utf8.
// ----------------------------------------------------------------------------
// Commands are queued up front: a directed set covering every op, each
// escape class and the UTF-8 length boundaries, then random quoted strings
// with some stray and unused commands mixed in. A clocked driver sends
// them in bursts. Each accepted command is turned into its expected bytes
// here and a clocked monitor checks every output beat against them, with
// the sink stalling on a changing pattern.
`timescale 1ns / 1ps

module tb;
  import jse_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused op, emits nothing
  localparam int N_RANDOM   = 350;
  localparam int DRAIN_CYC  = 20;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CP_W-1:0] cp;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] octet;
    logic              is_last;
  } out_beat_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SLOW,
    SINK_PATTERN
  } sink_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [BYTE_W-1:0]   m_tdata;
  logic                m_tlast;

  cmd_t       pending_cmds[$];
  out_beat_t  bytes_due[$];
  int         n_total    = 0;
  int         n_accepted = 0;
  int         n_errors   = 0;
  int         gap_left   = 0;
  int         burst_left = 1;
  int         mode_left  = 0;
  int         cyc        = 0;
  sink_mode_t sink_mode  = SINK_OPEN;

  json_string_escape_utf8 i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = "0" + nib;
    end else begin
      r = "A" + (nib - 4'd10);
    end
    return r;
  endfunction

  // Expected JSON bytes for one accepted command
  function automatic void push_escape(input cmd_t c);
    logic [BYTE_W-1:0] seq[SEQ_MAX];
    int                n;
    out_beat_t         b;
    n = 0;
    if (c.op == OP_OPEN || c.op == OP_CLOSE) begin
      seq[0] = CH_QUOTE;
      n = 1;
    end else if (c.op == OP_CHAR) begin
      if (c.cp == CH_QUOTE || c.cp == CH_BSL) begin
        seq[0] = CH_BSL;
        seq[1] = c.cp[7:0];
        n = 2;
      end else if (c.cp == CH_LF) begin
        seq[0] = CH_BSL;
        seq[1] = CH_N;
        n = 2;
      end else if (c.cp == CH_TAB) begin
        seq[0] = CH_BSL;
        seq[1] = CH_T;
        n = 2;
      end else if (c.cp < CTRL_LIMIT) begin
        seq[0] = CH_BSL;
        seq[1] = CH_U;
        seq[2] = CH_ZERO;
        seq[3] = CH_ZERO;
        seq[4] = hex_digit(c.cp[7:4]);
        seq[5] = hex_digit(c.cp[3:0]);
        n = 6;
      end else if (c.cp < 21'h80) begin
        seq[0] = c.cp[7:0];
        n = 1;
      end else if (c.cp < 21'h800) begin
        seq[0] = {3'b110, c.cp[10:6]};
        seq[1] = {2'b10, c.cp[5:0]};
        n = 2;
      end else if (c.cp < 21'h10000) begin
        seq[0] = {4'b1110, c.cp[15:12]};
        seq[1] = {2'b10, c.cp[11:6]};
        seq[2] = {2'b10, c.cp[5:0]};
        n = 3;
      end else begin
        seq[0] = {5'b11110, c.cp[20:18]};
        seq[1] = {2'b10, c.cp[17:12]};
        seq[2] = {2'b10, c.cp[11:6]};
        seq[3] = {2'b10, c.cp[5:0]};
        n = 4;
      end
    end
    for (int k = 0; k < n; k++) begin
      b.octet   = seq[k];
      b.is_last = (k == n - 1);
      bytes_due.push_back(b);
    end
  endfunction

  function automatic logic [CP_W-1:0] rand_code_point();
    logic [CP_W-1:0] cp;
    case ($urandom_range(0, 9))
      0: cp = CP_W'($urandom_range(32'h20, 32'h7E));
      1: cp = CP_W'($urandom_range(32'h20, 32'h7F));
      2: begin
        case ($urandom_range(0, 3))
          0: cp = CP_W'(CH_QUOTE);
          1: cp = CP_W'(CH_BSL);
          2: cp = CP_W'(CH_LF);
          default: cp = CP_W'(CH_TAB);
        endcase
      end
      3: cp = CP_W'($urandom_range(0, 31));
      4: cp = CP_W'($urandom_range(32'h80, 32'h7FF));
      5: cp = CP_W'($urandom_range(32'h800, 32'hFFFF));
      6: cp = CP_W'($urandom_range(32'hD800, 32'hDFFF));
      7: cp = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
      8: cp = CP_W'($urandom_range(32'h110000, 32'h1FFFFF));
      default: cp = CP_W'($urandom_range(0, 32'h1FFFFF));
    endcase
    return cp;
  endfunction

  task automatic add_cmd(input logic [OP_W-1:0] op, input logic [CP_W-1:0] cp);
    cmd_t c;
    c.op = op;
    c.cp = cp;
    pending_cmds.push_back(c);
    n_total++;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // Driver: bursts of beats, random gaps, held while the slave stalls
  always @(posedge clk) begin
    cmd_t c;
    cyc <= cyc + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        c.op = s_tdata[1:0];
        c.cp = s_tdata[22:2];
        push_escape(c);
        n_accepted++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.cp, c.op};
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink back-pressure, switching between a few stall styles
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 60);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_OPEN:    m_tready <= 1'b1;
        SINK_COIN:    m_tready <= 1'($urandom_range(0, 1));
        SINK_SLOW:    m_tready <= ($urandom_range(0, 3) == 0);
        default:      m_tready <= (cyc % 5 != 2) && (cyc % 7 != 0);
      endcase
    end
  end

  // Monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (bytes_due.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata, 0);
      end else begin
        want = bytes_due.pop_front();
        if (m_tdata !== want.octet) begin
          report_mismatch("out_byte", m_tdata, want.octet);
        end
        if (m_tlast !== want.is_last) begin
          report_mismatch("tlast", m_tlast, want.is_last);
        end
      end
    end
  end

  initial begin
    int n_real;
    int len;
    // directed: every op, each escape class, UTF-8 length edges
    add_cmd(OP_OPEN,  '0);
    add_cmd(OP_CLOSE, '1);
    add_cmd(OP_SPARE, '0);
    add_cmd(OP_CHAR,  CP_W'(CH_QUOTE));
    add_cmd(OP_CHAR,  CP_W'(CH_BSL));
    add_cmd(OP_CHAR,  CP_W'(CH_LF));
    add_cmd(OP_CHAR,  CP_W'(CH_TAB));
    add_cmd(OP_CHAR,  21'h00);
    add_cmd(OP_CHAR,  21'h0D);      // carriage return takes the \u form
    add_cmd(OP_CHAR,  21'h08);
    add_cmd(OP_CHAR,  21'h0C);
    add_cmd(OP_CHAR,  21'h1F);
    add_cmd(OP_CHAR,  21'h20);
    add_cmd(OP_CHAR,  21'h7F);
    add_cmd(OP_CHAR,  21'h80);
    add_cmd(OP_CHAR,  21'h7FF);
    add_cmd(OP_CHAR,  21'h800);
    add_cmd(OP_CHAR,  21'hD800);    // surrogates pass as plain 3-byte
    add_cmd(OP_CHAR,  21'hDFFF);
    add_cmd(OP_CHAR,  21'hFFFF);
    add_cmd(OP_CHAR,  21'h10000);
    add_cmd(OP_CHAR,  21'h10FFFF);
    add_cmd(OP_CHAR,  21'h110000);  // beyond Unicode, still 4-byte
    add_cmd(OP_CHAR,  21'h1FFFFF);
    add_cmd(OP_SPARE, '1);
    add_cmd(OP_OPEN,  '1);

    // random: mostly well-formed strings, some noise
    n_real = 0;
    while (n_real < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0: add_cmd(OP_SPARE, CP_W'($urandom_range(0, 32'h1FFFFF)));
        1: begin
          add_cmd($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE,
                  CP_W'($urandom_range(0, 32'h1FFFFF)));
          n_real++;
        end
        default: begin
          add_cmd(OP_OPEN, CP_W'($urandom_range(0, 32'h1FFFFF)));
          len = $urandom_range(0, 10);
          for (int k = 0; k < len; k++) begin
            add_cmd(OP_CHAR, rand_code_point());
          end
          n_real += len + 1;
          if ($urandom_range(0, 7) != 0) begin
            add_cmd(OP_CLOSE, CP_W'($urandom_range(0, 32'h1FFFFF)));
            n_real++;
          end
        end
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_total && bytes_due.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_errors == 0) begin
      $display("json_string_escape_utf8 verification clean");
    end else begin
      $display("json_string_escape_utf8 verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("json_string_escape_utf8 verification failed");
    $finish;
  end

endmodule
